[design/arl_pkg.sv]
package arl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 5;
    localparam int CMD_W     = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

endpackage

[design/arl_ram.sv]
module arl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/array_list_append_remove.sv]
// Bounded ordered list of signed 32-bit words.
// Command channel: drive cmd and value with start high; the command is
// taken at a rising edge where start is high and busy is low.
// cmd: append at end, remove first entry equal to value (later entries
// move down one place), clear, or no operation.
// Every command gives one result: done is high for exactly one cycle with
// ok, count and empty_res. The receiver cannot stall; results must be taken
// in the cycle they appear.
// Append, clear, no-op and remove on an empty list show their result in
// the cycle after the transfer. Remove scans entries in order, a read state
// and a compare state per entry, up to the match, then moves each later
// entry down one place with a read state and a write state. Both loops
// use the single read and write ports of the entry RAM (registered read).
// A new command may be taken in the cycle done is shown.
// Configuration: cfg_data is written to the capacity register when
// cfg_valid and cfg_ready are high; cfg_ready is always high. Write it only
// while no command is in flight.
// Reset: count goes to zero, capacity to 16; RAM contents are not cleared.
module array_list_append_remove #(
    parameter int DEPTH = arl_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [arl_pkg::CMD_W-1:0]         cmd,
    input  logic signed [arl_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic                              ok,
    output logic [arl_pkg::CNT_W-1:0]         count,
    output logic                              empty_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arl_pkg::CNT_W-1:0]         cfg_data
);

    import arl_pkg::*;

    localparam int AW = $clog2(DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   cap_reg;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    logic               room;
    logic               more_after;
    logic               more_after_next;

    arl_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign room = (fill_reg < cap_reg) && (32'(fill_reg) < DEPTH);
    assign more_after = (32'(ptr_reg) + 32'd1) < 32'(fill_reg);
    assign more_after_next = (32'(ptr_reg) + 32'd2) < 32'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            cap_reg   <= CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_APPEND:
                        begin
                            done_next = 1'b1;
                            ok_next   = room;
                            if (room)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = value;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                value_next = value;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                            fill_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                mem_raddr  = ptr_reg;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (mem_rdata == value_reg)
                begin
                    if (more_after)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        fill_next  = fill_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (more_after)
                begin
                    ptr_next   = AW'(32'(ptr_reg) + 32'd1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    ok_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT_RD:
            begin
                mem_raddr  = AW'(32'(ptr_reg) + 32'd1);
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = AW'(32'(ptr_reg) + 32'd1);
                if (more_after_next)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    fill_next  = fill_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign count     = fill_reg;
    assign empty_res = (fill_reg == '0);

endmodule
